>>> rtl/cipf_pkg.sv
// Shared types and constants for the comma-led integer field parser.
package cipf_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned ACC_W      = VALUE_W + 4;

    // Result queue geometry
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_WANTED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE = 8'd1;

    localparam logic [CFG_DATA_W-1:0] TOKENS_WANTED_RST = 8'd1;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    // Magnitude limits for signed and unsigned decoding
    localparam logic [ACC_W-1:0] LIMIT_SIGNED   = 36'h0_7FFF_FFFF;
    localparam logic [ACC_W-1:0] LIMIT_UNSIGNED = 36'h0_FFFF_FFFF;

    localparam logic KIND_INT    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_SIGN   = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_COMMA  = 2'd1,
        ST_NO_NUMBER = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic               result_kind;
        logic [INDEX_W-1:0] field_index;
        logic [VALUE_W-1:0] field_value;
        t_status            parse_status;
        logic               final_flag;
    } t_result;

endpackage

>>> rtl/cipf_if.sv
// Channel interfaces: text input, result output and configuration write.
interface cipf_in_if;
    import cipf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface cipf_out_if;
    import cipf_pkg::*;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [INDEX_W-1:0] field_index;
    logic [VALUE_W-1:0] field_value;
    logic [1:0]         parse_status;
    logic               final_flag;

    modport source (output valid, output result_kind, output field_index,
                    output field_value, output parse_status, output final_flag,
                    input ready);
    modport sink   (input valid, input result_kind, input field_index,
                    input field_value, input parse_status, input final_flag,
                    output ready);
endinterface

interface cipf_cfg_if;
    import cipf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/comma_integer_field_parser_core.sv
// Top level of the comma-led decimal integer field parser.
//
// Usage:
//   i_text carries one string byte per item; byte 0 ends the string. The
//   parser skips to a comma, then takes optional blanks, an optional sign
//   and a digit run. o_result carries one result per item: a decoded
//   integer with its index, or a final status (success, comma missing, no
//   number, overflow) with final_flag set. One byte can cause two results.
//   i_cfg writes tokens_wanted (index 0) and unsigned_mode (index 1); it is
//   always ready and a write takes effect on the next cycle.
// Latency and throughput:
//   A byte is decoded in the cycle it is accepted; its results leave the
//   result queue from the next cycle on. One byte is taken every cycle as
//   long as the four-entry result queue has room for two results, so the
//   rate is one byte per cycle and is set only by how fast o_result drains.
// Reset:
//   i_rst_n clears the parse state, empties the queue and restores
//   tokens_wanted to 1 and unsigned_mode to 0.
// Stalls:
//   While o_result.ready is low results hold in the queue; i_text.ready
//   drops once fewer than two entries are free, and no result is lost.
module comma_integer_field_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cipf_in_if.sink    i_text,
    cipf_out_if.source o_result,
    cipf_cfg_if.sink   i_cfg
);
    import cipf_pkg::*;

    // Configuration registers
    logic [INDEX_W-1:0] r_wanted;
    logic               r_unsigned;

    // Parse state
    t_phase             r_phase,    n_phase;
    logic               r_neg,      n_neg;
    logic [VALUE_W-1:0] r_mag,      n_mag;
    logic [INDEX_W-1:0] r_done,     n_done;
    logic               r_finished, n_finished;

    // Result queue
    t_result             r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count,  n_count;

    logic              in_acc;
    logic              out_acc;
    logic [BYTE_W-1:0] c;

    // Decode of the current byte against the parse state
    logic               is_digit, is_blank, is_sign;
    logic [3:0]         digit_val;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   limit;
    logic [INDEX_W-1:0] done_inc;
    logic               active, early_ok, in_digits, ovf, take_digit;
    logic               emit_int, late_ok, seek_step;
    logic               lead_step, sign_step, no_number;
    logic               emit_status, restart;
    t_status            status_code;

    // Results of this byte
    t_result          res0, res1;
    logic [1:0]       push_n;

    assign c       = i_text.text_byte;
    assign in_acc  = i_text.valid & i_text.ready;
    assign out_acc = o_result.valid & o_result.ready;

    // Leave room for the two results one byte can cause
    assign i_text.ready = (r_count <= QCOUNT_W'(QDEPTH - 2));
    assign i_cfg.ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted   <= TOKENS_WANTED_RST;
            r_unsigned <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TOKENS_WANTED: r_wanted   <= i_cfg.data;
                CFG_UNSIGNED_MODE: r_unsigned <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Character classes and the multiply-by-ten step (shift and add)
    always_comb begin
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
        digit_val = 4'(c - CH_ZERO);
        acc_next  = (ACC_W'(r_mag) << 3) + (ACC_W'(r_mag) << 1) + ACC_W'(digit_val);
        limit     = r_unsigned ? LIMIT_UNSIGNED : LIMIT_SIGNED;
        done_inc  = r_done + INDEX_W'(1);
    end

    // Event decode: what this byte does
    always_comb begin
        active     = !r_finished;
        early_ok   = active && (r_done >= r_wanted);
        in_digits  = active && !early_ok && (r_phase == PH_DIGITS);
        ovf        = in_digits && is_digit && (acc_next > limit);
        take_digit = in_digits && is_digit && !ovf;
        emit_int   = in_digits && !is_digit;
        late_ok    = emit_int && (done_inc >= r_wanted);
        // A byte that ends a number is searched for the next comma too
        seek_step  = active && !early_ok &&
                     ((r_phase == PH_SEEK) || (emit_int && !late_ok));
        lead_step  = active && !early_ok && (r_phase == PH_LEAD);
        sign_step  = active && !early_ok && (r_phase == PH_SIGN);
        no_number  = (lead_step && !is_blank && !is_sign && !is_digit) ||
                     (sign_step && !is_digit);

        emit_status = 1'b0;
        status_code = ST_OK;
        if (early_ok || late_ok) begin
            emit_status = 1'b1;
            status_code = ST_OK;
        end else if (ovf) begin
            emit_status = 1'b1;
            status_code = ST_OVERFLOW;
        end else if (no_number) begin
            emit_status = 1'b1;
            status_code = ST_NO_NUMBER;
        end else if (seek_step && (c == CH_NUL)) begin
            emit_status = 1'b1;
            status_code = ST_NO_COMMA;
        end

        // Terminator after a status, or with a status, opens a new string
        restart = (c == CH_NUL) && (r_finished || emit_status);
    end

    // Next parse state
    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_done     = r_done;
        n_finished = r_finished;
        if (restart) begin
            n_phase    = PH_SEEK;
            n_neg      = 1'b0;
            n_mag      = '0;
            n_done     = '0;
            n_finished = 1'b0;
        end else if (emit_status) begin
            n_finished = 1'b1;
        end else begin
            if (take_digit) begin
                n_mag = acc_next[VALUE_W-1:0];
            end
            if (emit_int) begin
                n_done  = done_inc;
                n_phase = PH_SEEK;
            end
            if (seek_step && (c == CH_COMMA)) begin
                n_phase = PH_LEAD;
                n_neg   = 1'b0;
                n_mag   = '0;
            end
            if ((lead_step || sign_step) && is_digit) begin
                n_mag   = VALUE_W'(digit_val);
                n_phase = PH_DIGITS;
            end
            if (lead_step && is_sign) begin
                n_neg   = (c == CH_MINUS);
                n_phase = PH_SIGN;
            end
        end
    end

    // Results of this byte, in order
    always_comb begin
        t_result int_res;
        t_result sts_res;
        int_res.result_kind  = KIND_INT;
        int_res.field_index  = r_done;
        int_res.field_value  = r_neg ? (VALUE_W'(0) - r_mag) : r_mag;
        int_res.parse_status = ST_OK;
        int_res.final_flag   = 1'b0;

        sts_res.result_kind  = KIND_STATUS;
        sts_res.field_index  = '0;
        sts_res.field_value  = '0;
        sts_res.parse_status = status_code;
        sts_res.final_flag   = 1'b1;

        res0   = emit_int ? int_res : sts_res;
        res1   = sts_res;
        push_n = {1'b0, emit_int} + {1'b0, emit_status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK;
            r_neg      <= 1'b0;
            r_mag      <= '0;
            r_done     <= '0;
            r_finished <= 1'b0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_done     <= n_done;
            r_finished <= n_finished;
        end
    end

    // Queue storage: push up to two results per accepted byte
    always_ff @(posedge i_clk) begin
        if (in_acc && (push_n != 2'd0)) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_acc && (push_n == 2'd2)) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + QCOUNT_W'(push_n);
        end
        if (out_acc) begin
            n_count = n_count - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(push_n);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Drive the head of the queue
    assign o_result.valid        = (r_count != '0);
    assign o_result.result_kind  = r_queue[r_rd_ptr].result_kind;
    assign o_result.field_index  = r_queue[r_rd_ptr].field_index;
    assign o_result.field_value  = r_queue[r_rd_ptr].field_value;
    assign o_result.parse_status = r_queue[r_rd_ptr].parse_status;
    assign o_result.final_flag   = r_queue[r_rd_ptr].final_flag;

    // Queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCOUNT_W'(QDEPTH))
        else $error("result queue over depth");

    // A decoded integer is offered on the very next cycle
    a_int_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit_int) |=> o_result.valid)
        else $error("decoded integer not queued");

    // Only a status result closes a string
    a_final_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.final_flag) |-> (o_result.result_kind == KIND_STATUS))
        else $error("final flag on an integer result");

    // No result once the string is finished, until the terminator
    a_quiet_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_finished) |-> (push_n == 2'd0))
        else $error("result after final status");

endmodule
